### rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// Saddle point search package
// Shared widths, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int ELEMENT_WIDTH   = 16;
    localparam int COUNT_WIDTH     = 4;
    localparam int POINT_WIDTH     = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } msp_state_t;

    typedef struct packed {
        logic load;
        logic check_done;
        logic push_held;
        logic flush;
    } msp_cmd_t;

    typedef struct packed {
        logic load_last;
        logic scan_last;
        logic hit;
        logic held_valid;
        logic out_free;
    } msp_status_t;

endpackage

### rtl/core/msp_element_if.sv
// ----------------------------------------------------------------------------
// Element stream interface
// Carries one signed matrix element per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface msp_element_if;

    logic                                     valid;
    logic                                     ready;
    logic signed [msp_pkg::ELEMENT_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);

endinterface

### rtl/core/msp_point_if.sv
// ----------------------------------------------------------------------------
// Saddle point result interface
// Carries one saddle point report per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface msp_point_if;

    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [msp_pkg::POINT_WIDTH-1:0] point_row;
    logic [msp_pkg::POINT_WIDTH-1:0] point_column;
    logic                            last_of_run;

    modport source (output valid, output found, output point_row, output point_column,
                    output last_of_run, input ready);
    modport sink (input valid, input found, input point_row, input point_column,
                  input last_of_run, output ready);

endinterface

### rtl/core/matrix_saddle_point_finder_unit.sv
// ----------------------------------------------------------------------------
// Matrix saddle point finder
// Loads a matrix element by element, then reports every saddle point.
// ----------------------------------------------------------------------------
// Elements arrive on elem_in in row-major order, one beat per cycle, filling
// a matrix of row_count by column_count entries (set through the write port;
// a count of zero acts as one, a count above the maximum acts as the maximum).
// A write to either count register restarts loading at the first element.
// Once the last element is taken, the block scans the stored matrix and
// sends one beat on point_out per saddle point in row-major order, the last
// marked by last_of_run. With no saddle point it sends a single beat with
// found low and last_of_run high.
// Each stored element passes through a read state and a check state, set by the
// single read port of the element store and the compare that follows it. While
// the scan runs, elem_in is not ready. A stall on point_out holds the scan at
// the next hit; the next matrix may be loaded while the final beat still waits.
// Reset restores both counts to their maximum and the load position to zero.
// ----------------------------------------------------------------------------
module matrix_saddle_point_finder_unit
#(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int DATA_WIDTH  = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    msp_element_if.sink                         elem_in,
    msp_point_if.source                         point_out,
    input  logic                                config_write,
    input  logic [msp_pkg::CFG_INDEX_WIDTH-1:0] config_index,
    input  logic [msp_pkg::CFG_DATA_WIDTH-1:0]  config_data
);

    msp_pkg::msp_cmd_t    cmd;
    msp_pkg::msp_status_t status;
    logic                 in_ready;

    msp_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (elem_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    msp_datapath
    #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .DATA_WIDTH  (DATA_WIDTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .config_write  (config_write),
        .config_index  (config_index),
        .config_data   (config_data),
        .element_value (elem_in.element_value),
        .cmd           (cmd),
        .status        (status),
        .point_valid   (point_out.valid),
        .point_ready   (point_out.ready),
        .found         (point_out.found),
        .point_row     (point_out.point_row),
        .point_column  (point_out.point_column),
        .last_of_run   (point_out.last_of_run)
    );

    assign elem_in.ready = in_ready;

endmodule

### rtl/core/msp_controller.sv
// ----------------------------------------------------------------------------
// Saddle point search controller
// Sequences loading, the element-by-element scan and the final report.
// ----------------------------------------------------------------------------
module msp_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  msp_pkg::msp_status_t status,
    output msp_pkg::msp_cmd_t    cmd
);

    msp_pkg::msp_state_t state_reg;
    msp_pkg::msp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msp_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            msp_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.load_last)
                    begin
                        state_next = msp_pkg::ST_READ;
                    end
                end
            end
            msp_pkg::ST_READ:
            begin
                state_next = msp_pkg::ST_CHECK;
            end
            msp_pkg::ST_CHECK:
            begin
                if (!(status.hit && status.held_valid && !status.out_free))
                begin
                    cmd.check_done = 1'b1;
                    cmd.push_held  = status.hit && status.held_valid;
                    state_next     = status.scan_last ? msp_pkg::ST_FLUSH : msp_pkg::ST_READ;
                end
            end
            msp_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = msp_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = msp_pkg::ST_LOAD;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::ST_LOAD && in_valid && status.load_last)
        |=> (state_reg == msp_pkg::ST_READ))
        else $error("Scan did not start after the last element.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::ST_CHECK && cmd.check_done && status.scan_last)
        |=> (state_reg == msp_pkg::ST_FLUSH))
        else $error("Final report skipped after the last scanned element.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msp_pkg::ST_FLUSH && status.out_free) |=> (state_reg == msp_pkg::ST_LOAD))
        else $error("Controller did not return to loading after the report.");

endmodule

### rtl/core/msp_datapath.sv
// ----------------------------------------------------------------------------
// Saddle point search datapath
// Element store, running row maxima and column minima, scan pointer,
// held hit and the output register.
// ----------------------------------------------------------------------------
module msp_datapath
#(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int DATA_WIDTH  = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     config_write,
    input  logic [msp_pkg::CFG_INDEX_WIDTH-1:0]      config_index,
    input  logic [msp_pkg::CFG_DATA_WIDTH-1:0]       config_data,
    input  logic signed [msp_pkg::ELEMENT_WIDTH-1:0] element_value,
    input  msp_pkg::msp_cmd_t                        cmd,
    output msp_pkg::msp_status_t                     status,
    output logic                                     point_valid,
    input  logic                                     point_ready,
    output logic                                     found,
    output logic [msp_pkg::POINT_WIDTH-1:0]          point_row,
    output logic [msp_pkg::POINT_WIDTH-1:0]          point_column,
    output logic                                     last_of_run
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [msp_pkg::COUNT_WIDTH-1:0] ROW_TOP = msp_pkg::COUNT_WIDTH'(MAX_ROWS);
    localparam logic [msp_pkg::COUNT_WIDTH-1:0] COL_TOP = msp_pkg::COUNT_WIDTH'(MAX_COLUMNS);
    localparam logic [msp_pkg::COUNT_WIDTH-1:0] ONE     = msp_pkg::COUNT_WIDTH'(1);

    logic [msp_pkg::COUNT_WIDTH-1:0] row_count_reg;
    logic [msp_pkg::COUNT_WIDTH-1:0] column_count_reg;
    logic [msp_pkg::COUNT_WIDTH-1:0] rows_eff;
    logic [msp_pkg::COUNT_WIDTH-1:0] cols_eff;

    logic [RW-1:0] load_row_reg;
    logic [CW-1:0] load_col_reg;
    logic [RW-1:0] load_row;
    logic [CW-1:0] load_col;
    logic          load_col_last;
    logic          load_row_last;

    logic [RW-1:0] scan_row_reg;
    logic [CW-1:0] scan_col_reg;
    logic          scan_col_last;
    logic          scan_row_last;

    logic signed [DATA_WIDTH-1:0] elem_data;
    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_data_reg;
    logic signed [DATA_WIDTH-1:0] row_max_reg [MAX_ROWS];
    logic signed [DATA_WIDTH-1:0] col_min_reg [MAX_COLUMNS];
    logic [AW-1:0]                load_addr;
    logic [AW-1:0]                scan_addr;

    logic          held_valid_reg;
    logic [RW-1:0] held_row_reg;
    logic [CW-1:0] held_col_reg;

    logic                            out_valid_reg;
    logic                            found_reg;
    logic [msp_pkg::POINT_WIDTH-1:0] row_out_reg;
    logic [msp_pkg::POINT_WIDTH-1:0] col_out_reg;
    logic                            last_reg;

    generate
        if (DATA_WIDTH <= msp_pkg::ELEMENT_WIDTH)
        begin : g_narrow
            assign elem_data = $signed(element_value[DATA_WIDTH-1:0]);
        end
        else
        begin : g_wide
            assign elem_data = $signed({{(DATA_WIDTH - msp_pkg::ELEMENT_WIDTH){1'b0}},
                                        element_value});
        end
    endgenerate

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = ONE;
        end
        else if (row_count_reg > ROW_TOP)
        begin
            rows_eff = ROW_TOP;
        end
        else
        begin
            rows_eff = row_count_reg;
        end
        if (column_count_reg == '0)
        begin
            cols_eff = ONE;
        end
        else if (column_count_reg > COL_TOP)
        begin
            cols_eff = COL_TOP;
        end
        else
        begin
            cols_eff = column_count_reg;
        end
    end

    assign load_row = (msp_pkg::COUNT_WIDTH'(load_row_reg) >= rows_eff)
                      ? RW'(rows_eff - ONE) : load_row_reg;
    assign load_col = (msp_pkg::COUNT_WIDTH'(load_col_reg) >= cols_eff)
                      ? CW'(cols_eff - ONE) : load_col_reg;
    assign load_col_last = (msp_pkg::COUNT_WIDTH'(load_col) + ONE) >= cols_eff;
    assign load_row_last = (msp_pkg::COUNT_WIDTH'(load_row) + ONE) >= rows_eff;
    assign scan_col_last = (msp_pkg::COUNT_WIDTH'(scan_col_reg) + ONE) >= cols_eff;
    assign scan_row_last = (msp_pkg::COUNT_WIDTH'(scan_row_reg) + ONE) >= rows_eff;

    assign load_addr = AW'(int'(load_row) * MAX_COLUMNS + int'(load_col));
    assign scan_addr = AW'(int'(scan_row_reg) * MAX_COLUMNS + int'(scan_col_reg));

    assign status.load_last  = load_row_last && load_col_last;
    assign status.scan_last  = scan_row_last && scan_col_last;
    assign status.hit        = (rd_data_reg == row_max_reg[scan_row_reg])
                               && (rd_data_reg == col_min_reg[scan_col_reg]);
    assign status.held_valid = held_valid_reg;
    assign status.out_free   = !out_valid_reg || point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_TOP;
            column_count_reg <= COL_TOP;
            load_row_reg     <= '0;
            load_col_reg     <= '0;
        end
        else if (config_write && (config_index == msp_pkg::REG_ROW_COUNT
                                  || config_index == msp_pkg::REG_COLUMN_COUNT))
        begin
            if (config_index == msp_pkg::REG_ROW_COUNT)
            begin
                row_count_reg <= config_data;
            end
            else
            begin
                column_count_reg <= config_data;
            end
            load_row_reg <= '0;
            load_col_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (!load_col_last)
            begin
                load_row_reg <= load_row;
                load_col_reg <= load_col + CW'(1);
            end
            else if (!load_row_last)
            begin
                load_row_reg <= load_row + RW'(1);
                load_col_reg <= '0;
            end
            else
            begin
                load_row_reg <= '0;
                load_col_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[load_addr] <= elem_data;
        end
        rd_data_reg <= mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (load_col == '0 || elem_data > row_max_reg[load_row])
            begin
                row_max_reg[load_row] <= elem_data;
            end
            if (load_row == '0 || elem_data < col_min_reg[load_col])
            begin
                col_min_reg[load_col] <= elem_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_row_reg <= '0;
                scan_col_reg <= '0;
            end
            else if (cmd.check_done)
            begin
                if (!scan_col_last)
                begin
                    scan_col_reg <= scan_col_reg + CW'(1);
                end
                else
                begin
                    scan_col_reg <= '0;
                    scan_row_reg <= scan_row_reg + RW'(1);
                end
            end
            if (cmd.check_done && status.hit)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check_done && status.hit)
        begin
            held_row_reg <= scan_row_reg;
            held_col_reg <= scan_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_held || cmd.flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (point_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // A flush with no held hit reports the no-saddle marker.
    always_ff @(posedge clk)
    begin
        if (cmd.push_held || cmd.flush)
        begin
            found_reg   <= held_valid_reg;
            row_out_reg <= held_valid_reg ? msp_pkg::POINT_WIDTH'(held_row_reg) : '0;
            col_out_reg <= held_valid_reg ? msp_pkg::POINT_WIDTH'(held_col_reg) : '0;
            last_reg    <= cmd.flush;
        end
    end

    assign point_valid  = out_valid_reg;
    assign found        = found_reg;
    assign point_row    = row_out_reg;
    assign point_column = col_out_reg;
    assign last_of_run  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !point_ready) |-> !(cmd.push_held || cmd.flush))
        else $error("Output register overwritten before its beat was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_held |-> (held_valid_reg && !cmd.flush))
        else $error("Held hit pushed without a valid hit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (!held_valid_reg && out_valid_reg && last_reg))
        else $error("Final report not formed correctly.");

endmodule

### tb/matrix_saddle_point_finder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix saddle point finder testbench
// Streams matrices of many shapes and contents into the finder and checks
// every reported saddle point against a cycle-free prediction of the block.
// Directed tests cover extreme values, count clamping, the no-saddle marker,
// restart on a register write and writes to unused indexes. Random phases
// vary the matrix shape and content and the idling on both channels. A long
// receiver hold-off fills the block while the sender keeps offering beats.
// ----------------------------------------------------------------------------
module matrix_saddle_point_finder_unit_tb;

    localparam int MAX_ROWS           = 8;
    localparam int MAX_COLUMNS        = 8;
    localparam int CLOCK_PERIOD       = 20;
    localparam int RESET_CYCLES       = 7;
    localparam int SCAN_SETTLE_CYCLES = 2 * MAX_ROWS * MAX_COLUMNS + 12;
    localparam int WATCHDOG_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int PHASE_ITEMS        = 57;

    localparam logic [msp_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [msp_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_3 = 2'd3;

    localparam logic signed [msp_pkg::ELEMENT_WIDTH-1:0] ELEMENT_MIN = 16'sh8000;
    localparam logic signed [msp_pkg::ELEMENT_WIDTH-1:0] ELEMENT_MAX = 16'sh7fff;

    typedef struct packed {
        logic                            found;
        logic [msp_pkg::POINT_WIDTH-1:0] point_row;
        logic [msp_pkg::POINT_WIDTH-1:0] point_column;
        logic                            last_of_run;
    } saddle_point_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_TIES,
        FILL_CONSTANT,
        FILL_PLANTED,
        FILL_EXTREME
    } fill_mode_t;

    logic                                clk;
    logic                                rst_n;
    logic                                config_write;
    logic [msp_pkg::CFG_INDEX_WIDTH-1:0] config_index;
    logic [msp_pkg::CFG_DATA_WIDTH-1:0]  config_data;

    msp_element_if element_bus ();
    msp_point_if   point_bus ();

    matrix_saddle_point_finder_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .DATA_WIDTH  (msp_pkg::ELEMENT_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_in      (element_bus),
        .point_out    (point_bus),
        .config_write (config_write),
        .config_index (config_index),
        .config_data  (config_data)
    );

    logic signed [msp_pkg::ELEMENT_WIDTH-1:0] matrix_store [MAX_ROWS*MAX_COLUMNS];
    logic signed [msp_pkg::ELEMENT_WIDTH-1:0] row_max [MAX_ROWS];
    logic signed [msp_pkg::ELEMENT_WIDTH-1:0] column_min [MAX_COLUMNS];
    int                                       load_row;
    int                                       load_column;
    logic [msp_pkg::COUNT_WIDTH-1:0]          model_row_count;
    logic [msp_pkg::COUNT_WIDTH-1:0]          model_column_count;

    saddle_point_t expected_points [$];
    int            error_count;
    int            items_accepted;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_request;
    int            quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLOCK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic int effective_count(logic [msp_pkg::COUNT_WIDTH-1:0] value, int top);
        if (value == 0)
        begin
            return 1;
        end
        if (int'(value) > top)
        begin
            return top;
        end
        return int'(value);
    endfunction

    task automatic predict_element(input logic signed [msp_pkg::ELEMENT_WIDTH-1:0] value);
        int            rows;
        int            cols;
        int            r;
        int            c;
        int            hits;
        int            k;
        saddle_point_t point;
        rows = effective_count(model_row_count, MAX_ROWS);
        cols = effective_count(model_column_count, MAX_COLUMNS);
        r = (load_row >= rows) ? rows - 1 : load_row;
        c = (load_column >= cols) ? cols - 1 : load_column;
        matrix_store[r*MAX_COLUMNS+c] = value;
        if (c == 0 || value > row_max[r])
        begin
            row_max[r] = value;
        end
        if (r == 0 || value < column_min[c])
        begin
            column_min[c] = value;
        end
        if (c + 1 < cols)
        begin
            load_row = r;
            load_column = c + 1;
        end
        else if (r + 1 < rows)
        begin
            load_row = r + 1;
            load_column = 0;
        end
        else
        begin
            load_row = 0;
            load_column = 0;
            hits = 0;
            for (int i = 0; i < rows; i++)
            begin
                for (int j = 0; j < cols; j++)
                begin
                    if (matrix_store[i*MAX_COLUMNS+j] == row_max[i] &&
                        matrix_store[i*MAX_COLUMNS+j] == column_min[j])
                    begin
                        hits++;
                    end
                end
            end
            if (hits == 0)
            begin
                point = '{found: 1'b0, point_row: '0, point_column: '0, last_of_run: 1'b1};
                expected_points.push_back(point);
            end
            else
            begin
                k = 0;
                for (int i = 0; i < rows; i++)
                begin
                    for (int j = 0; j < cols; j++)
                    begin
                        if (matrix_store[i*MAX_COLUMNS+j] == row_max[i] &&
                            matrix_store[i*MAX_COLUMNS+j] == column_min[j])
                        begin
                            k++;
                            point.found        = 1'b1;
                            point.point_row    = msp_pkg::POINT_WIDTH'(i);
                            point.point_column = msp_pkg::POINT_WIDTH'(j);
                            point.last_of_run  = (k == hits);
                            expected_points.push_back(point);
                        end
                    end
                end
            end
        end
    endtask

    task automatic write_register(input logic [msp_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  input logic [msp_pkg::CFG_DATA_WIDTH-1:0] data);
        config_write <= 1'b1;
        config_index <= index;
        config_data  <= data;
        @(posedge clk);
        if (index == msp_pkg::REG_ROW_COUNT)
        begin
            model_row_count = data;
        end
        else if (index == msp_pkg::REG_COLUMN_COUNT)
        begin
            model_column_count = data;
        end
        if (index == msp_pkg::REG_ROW_COUNT || index == msp_pkg::REG_COLUMN_COUNT)
        begin
            load_row = 0;
            load_column = 0;
        end
        config_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_element(input logic signed [msp_pkg::ELEMENT_WIDTH-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            element_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        element_bus.valid         <= 1'b1;
        element_bus.element_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!element_bus.ready);
        predict_element(value);
        items_accepted++;
    endtask

    task automatic end_burst();
        element_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SCAN_SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_shape(input logic [msp_pkg::CFG_DATA_WIDTH-1:0] rows,
                             input logic [msp_pkg::CFG_DATA_WIDTH-1:0] cols);
        end_burst();
        wait_drained();
        write_register(msp_pkg::REG_ROW_COUNT, rows);
        write_register(msp_pkg::REG_COLUMN_COUNT, cols);
    endtask

    task automatic send_matrix(input fill_mode_t mode, input int count);
        int                                       rows;
        int                                       cols;
        int                                       base;
        int                                       sr;
        int                                       sc;
        int                                       sent;
        logic signed [msp_pkg::ELEMENT_WIDTH-1:0] value;
        rows = effective_count(model_row_count, MAX_ROWS);
        cols = effective_count(model_column_count, MAX_COLUMNS);
        base = int'($urandom_range(0, 60000)) - 30000;
        sr = $urandom_range(0, rows - 1);
        sc = $urandom_range(0, cols - 1);
        sent = 0;
        for (int i = 0; i < rows; i++)
        begin
            for (int j = 0; j < cols; j++)
            begin
                case (mode)
                    FILL_TIES:     value = 16'(int'($urandom_range(0, 4)) - 2);
                    FILL_CONSTANT: value = 16'(base);
                    FILL_PLANTED:
                    begin
                        if (i == sr && j == sc)
                        begin
                            value = 16'(base);
                        end
                        else if (i == sr)
                        begin
                            value = 16'(base - int'($urandom_range(1, 100)));
                        end
                        else if (j == sc)
                        begin
                            value = 16'(base + int'($urandom_range(1, 100)));
                        end
                        else
                        begin
                            value = 16'($urandom());
                        end
                    end
                    FILL_EXTREME:
                    begin
                        case ($urandom_range(3))
                            0:       value = ELEMENT_MIN;
                            1:       value = ELEMENT_MAX;
                            2:       value = '0;
                            default: value = '1;
                        endcase
                    end
                    default:       value = 16'($urandom());
                endcase
                if (count < 0 || sent < count)
                begin
                    send_element(value);
                    sent++;
                end
            end
        end
    endtask

    function automatic logic [msp_pkg::CFG_DATA_WIDTH-1:0] pick_count();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick < 8)
        begin
            return msp_pkg::CFG_DATA_WIDTH'($urandom_range(1, 4));
        end
        else if (pick == 8)
        begin
            return '0;
        end
        else if (pick == 9)
        begin
            return msp_pkg::CFG_DATA_WIDTH'(MAX_ROWS);
        end
        else if (pick == 10)
        begin
            return msp_pkg::CFG_DATA_WIDTH'($urandom_range(9, 15));
        end
        return msp_pkg::CFG_DATA_WIDTH'($urandom_range(5, 8));
    endfunction

    task automatic test_single_element();
        set_shape(4'd1, 4'd1);
        send_element(ELEMENT_MIN);
        send_element(ELEMENT_MAX);
        end_burst();
    endtask

    task automatic test_count_clamp();
        logic signed [msp_pkg::ELEMENT_WIDTH-1:0] column_values [8];
        logic signed [msp_pkg::ELEMENT_WIDTH-1:0] row_values [8];
        column_values = '{16'sd7, -16'sd1, ELEMENT_MAX, ELEMENT_MIN,
                          16'sd0, ELEMENT_MIN, 16'sd3, -16'sd32767};
        row_values = '{16'sd1, ELEMENT_MAX, 16'sd0, ELEMENT_MIN,
                       -16'sd1, ELEMENT_MAX, 16'sd32766, 16'sd5};
        set_shape(4'd9, 4'd0);
        foreach (column_values[i])
        begin
            send_element(column_values[i]);
        end
        set_shape(4'd0, 4'd15);
        foreach (row_values[i])
        begin
            send_element(row_values[i]);
        end
        end_burst();
    endtask

    task automatic test_no_saddle();
        set_shape(4'd2, 4'd2);
        send_element(16'sd1);
        send_element(16'sd2);
        send_element(16'sd2);
        send_element(16'sd1);
        end_burst();
    endtask

    task automatic test_load_restart();
        set_shape(4'd2, 4'd2);
        send_element(ELEMENT_MAX);
        end_burst();
        wait_drained();
        write_register(msp_pkg::REG_COLUMN_COUNT, 4'd1);
        send_element(-16'sd4);
        send_element(16'sd9);
        end_burst();
    endtask

    task automatic test_unused_index();
        send_element(16'sd6);
        end_burst();
        wait_drained();
        write_register(REG_UNUSED_2, 4'd5);
        write_register(REG_UNUSED_3, 4'hf);
        send_element(16'sd6);
        end_burst();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_shape(4'd8, 4'd8);
        hold_request = HOLD_OFF_CYCLES;
        send_matrix(FILL_CONSTANT, -1);
        send_matrix(FILL_TIES, -1);
        end_burst();
        wait_drained();
    endtask

    task automatic test_random_matrices(input int send_pct, input int recv_pct);
        int         target;
        int         matrices;
        int         size;
        fill_mode_t mode;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = items_accepted + PHASE_ITEMS;
        while (items_accepted < target)
        begin
            set_shape(pick_count(), pick_count());
            matrices = $urandom_range(1, 3);
            for (int m = 0; m < matrices; m++)
            begin
                mode = fill_mode_t'($urandom_range(0, 4));
                size = effective_count(model_row_count, MAX_ROWS) *
                       effective_count(model_column_count, MAX_COLUMNS);
                if ($urandom_range(9) == 0 && size > 1)
                begin
                    send_matrix(mode, $urandom_range(1, size - 1));
                    end_burst();
                    wait_drained();
                    write_register(msp_pkg::REG_ROW_COUNT, model_row_count);
                end
                else
                begin
                    send_matrix(mode, -1);
                end
            end
        end
        end_burst();
        wait_drained();
    endtask

    initial
    begin
        point_bus.ready <= 1'b0;
        forever
        begin
            int hold_left;
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                point_bus.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                point_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        saddle_point_t want;
        if (rst_n && point_bus.valid && point_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected beat: found %0d row %0d column %0d last %0d",
                       point_bus.found, point_bus.point_row, point_bus.point_column,
                       point_bus.last_of_run);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (point_bus.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, point_bus.found);
                    error_count++;
                end
                if (point_bus.point_row !== want.point_row)
                begin
                    $error("point_row: expected %0d, actual %0d",
                           want.point_row, point_bus.point_row);
                    error_count++;
                end
                if (point_bus.point_column !== want.point_column)
                begin
                    $error("point_column: expected %0d, actual %0d",
                           want.point_column, point_bus.point_column);
                    error_count++;
                end
                if (point_bus.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, point_bus.last_of_run);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((element_bus.valid && element_bus.ready) || (point_bus.valid && point_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("** matrix_saddle_point_finder_unit: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n                     <= 1'b0;
        config_write              <= 1'b0;
        config_index              <= '0;
        config_data               <= '0;
        element_bus.valid         <= 1'b0;
        element_bus.element_value <= '0;
        quiet_cycles              = 0;
        error_count               = 0;
        items_accepted            = 0;
        send_idle_pct             = 0;
        recv_idle_pct             = 0;
        hold_request              = 0;
        load_row                  = 0;
        load_column               = 0;
        model_row_count           = 4'd8;
        model_column_count        = 4'd8;
        foreach (matrix_store[i])
        begin
            matrix_store[i] = '0;
        end
        foreach (row_max[i])
        begin
            row_max[i] = '0;
        end
        foreach (column_min[i])
        begin
            column_min[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element();
        test_count_clamp();
        test_no_saddle();
        test_load_restart();
        test_unused_index();
        test_random_matrices(0, 0);
        test_backpressure();
        test_random_matrices(58, 0);
        test_random_matrices(0, 58);
        test_random_matrices(25, 25);

        end_burst();
        wait_drained();
        if (error_count == 0)
        begin
            $display("** matrix_saddle_point_finder_unit: PASSED **");
        end
        else
        begin
            $display("** matrix_saddle_point_finder_unit: FAILED **");
        end
        $finish;
    end

endmodule
